FILE: rtl/core/bfba_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bfba_pkg
// Shared widths, codes and controller/datapath interface types for the
// best-fit block allocator.
// ----------------------------------------------------------------------------
package bfba_pkg;

    localparam int IDX_W  = 4;   // block_index / chosen_block
    localparam int SZ_W   = 16;  // size_value / remaining_size
    localparam int CNT_W  = 5;   // block_count register
    localparam int STAT_W = 2;   // status
    localparam int DATA_W = 24;  // tdata, padded to whole bytes

    localparam logic ACT_LOAD    = 1'b0;
    localparam logic ACT_REQUEST = 1'b1;

    localparam logic [STAT_W-1:0] ST_LOADED = 2'd0;
    localparam logic [STAT_W-1:0] ST_ALLOC  = 2'd1;
    localparam logic [STAT_W-1:0] ST_NONE   = 2'd2;

    localparam logic [CNT_W-1:0] BLOCK_COUNT_RST = 5'd16;

    // controller -> datapath
    typedef struct packed {
        logic capture;  // latch the accepted input transaction
        logic scan;     // step the search over the free-size store
        logic finish;   // commit the write-back and load the output register
    } ctrl_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic scan_done;
    } dp_status_t;

endpackage
`default_nettype wire

FILE: rtl/core/best_fit_block_allocator.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// best_fit_block_allocator
// Keeps a free size per memory block and serves best-fit allocation requests.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream (s_*): tuser[0] selects load (0) or request (1); tdata carries
//   the block index and the size. A load writes one block's free size; a
//   request picks the block with the smallest free size still at least the
//   request (lowest index on ties) and takes the request off it.
//   Result stream (m_*): one per input; tuser status, tdata block and size.
//   Config channel (cfg_*): block_count, the number of blocks searched from
//   index zero; write it only while the block is idle.
// Search: a request reads n = min(block_count, NUM_BLOCKS) entries of the store,
//   one entry per cycle, from index zero; the input reopens as the result
//   appears, so only one item is in work at a time.
// Reset: all free sizes read as zero, block_count returns to 16.
// Stall: the result waits in the output register; the next input is still
//   taken and worked on, and its result is held until the register empties.
// ----------------------------------------------------------------------------
module best_fit_block_allocator #(
    parameter int NUM_BLOCKS = 16,
    parameter int SIZE_BITS  = 16
) (
    input  wire                               aclk,
    input  wire                               aresetn,
    input  wire                               s_tvalid,
    output logic                              s_tready,
    input  wire [bfba_pkg::DATA_W-1:0]        s_tdata,   // [3:0] block_index, [19:4] size_value
    input  wire [0:0]                         s_tuser,   // [0] action
    output logic                              m_tvalid,
    input  wire                               m_tready,
    output logic [bfba_pkg::DATA_W-1:0]       m_tdata,   // [3:0] chosen_block, [19:4] remaining_size
    output logic [bfba_pkg::STAT_W-1:0]       m_tuser,   // [1:0] status
    input  wire                               cfg_valid,
    output logic                              cfg_ready,
    input  wire [bfba_pkg::CNT_W-1:0]         cfg_data   // block_count
);

    bfba_pkg::ctrl_cmd_t  cmd;
    bfba_pkg::dp_status_t status;

    logic [bfba_pkg::IDX_W-1:0] res_block;
    logic [bfba_pkg::SZ_W-1:0]  res_remaining;

    assign cfg_ready = 1'b1;
    assign m_tdata   = {4'd0, res_remaining, res_block};

    bfba_controller u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_tvalid),
        .s_ready  (s_tready),
        .s_action (s_tuser[0]),
        .m_valid  (m_tvalid),
        .m_ready  (m_tready),
        .cmd      (cmd),
        .status   (status)
    );

    bfba_datapath #(
        .NUM_BLOCKS (NUM_BLOCKS),
        .SIZE_BITS  (SIZE_BITS)
    ) u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .status        (status),
        .in_action     (s_tuser[0]),
        .in_index      (s_tdata[3:0]),
        .in_size       (s_tdata[19:4]),
        .cfg_wr        (cfg_valid && cfg_ready),
        .cfg_data      (cfg_data),
        .res_status    (m_tuser),
        .res_block     (res_block),
        .res_remaining (res_remaining)
    );

endmodule
`default_nettype wire

FILE: rtl/core/bfba_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bfba_datapath
// Free-size store, block count register, best-fit search registers and
// result payload register.
// ----------------------------------------------------------------------------
module bfba_datapath #(
    parameter int NUM_BLOCKS = 16,
    parameter int SIZE_BITS  = 16
) (
    input  wire                              aclk,
    input  wire                              aresetn,
    input  wire bfba_pkg::ctrl_cmd_t         cmd,
    output bfba_pkg::dp_status_t             status,
    input  wire                              in_action,
    input  wire [bfba_pkg::IDX_W-1:0]        in_index,
    input  wire [bfba_pkg::SZ_W-1:0]         in_size,
    input  wire                              cfg_wr,
    input  wire [bfba_pkg::CNT_W-1:0]        cfg_data,
    output logic [bfba_pkg::STAT_W-1:0]      res_status,
    output logic [bfba_pkg::IDX_W-1:0]       res_block,
    output logic [bfba_pkg::SZ_W-1:0]        res_remaining
);

    localparam int AW = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
    localparam logic [31:0] NB32 = NUM_BLOCKS;

    logic [SIZE_BITS-1:0] mem [NUM_BLOCKS];
    logic [NUM_BLOCKS-1:0] valid_reg;

    logic [bfba_pkg::CNT_W-1:0] count_reg;
    logic                       act_reg;
    logic [bfba_pkg::IDX_W-1:0] idx_reg;
    logic [SIZE_BITS-1:0]       size_reg;

    logic [bfba_pkg::CNT_W-1:0] scan_idx_reg, scan_idx_next;
    logic [bfba_pkg::CNT_W-1:0] cmp_idx_reg;
    logic                       cmp_en_reg, cmp_en_next;
    logic [bfba_pkg::CNT_W-1:0] best_idx_reg, best_idx_next;
    logic [SIZE_BITS-1:0]       best_free_reg, best_free_next;
    logic                       found_reg, found_next;

    logic [SIZE_BITS-1:0] rd_mem_reg;
    logic                 rd_vld_reg;
    logic [SIZE_BITS-1:0] rd_free;

    logic [bfba_pkg::CNT_W-1:0] n_search;
    logic                       issue;
    logic [31:0]                scan_ext, idx_ext, best_ext;
    logic [AW-1:0]              rd_addr, wr_addr;
    logic                       wr_en;
    logic [SIZE_BITS-1:0]       wr_data;
    logic [SIZE_BITS-1:0]       diff;
    logic                       idx_in_range;
    logic [SIZE_BITS+15:0]      in_size_ext;
    logic [SIZE_BITS+15:0]      size_ext, diff_ext;

    // searched blocks saturate at the store depth
    assign n_search = ({27'd0, count_reg} > NB32) ? NB32[bfba_pkg::CNT_W-1:0] : count_reg;
    assign issue    = cmd.scan && (scan_idx_reg < n_search);

    assign scan_ext = {27'd0, scan_idx_reg};
    assign idx_ext  = {28'd0, idx_reg};
    assign best_ext = {27'd0, best_idx_reg};
    assign rd_addr  = scan_ext[AW-1:0];
    assign idx_in_range = (idx_ext < NB32);

    assign in_size_ext = {{SIZE_BITS{1'b0}}, in_size};
    assign rd_free  = rd_vld_reg ? rd_mem_reg : '0;
    assign diff     = best_free_reg - size_reg;
    assign size_ext = {16'd0, size_reg};
    assign diff_ext = {16'd0, diff};

    assign status.scan_done = (scan_idx_reg >= n_search) && !cmp_en_reg;

    // write-back on completion: a load in range, or an allocation that found a block
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = idx_ext[AW-1:0];
        wr_data = size_reg;
        if (cmd.finish) begin
            if (act_reg == bfba_pkg::ACT_LOAD) begin
                wr_en = idx_in_range;
            end else begin
                wr_en   = found_reg;
                wr_addr = best_ext[AW-1:0];
                wr_data = diff;
            end
        end
    end

    always_comb begin
        scan_idx_next  = scan_idx_reg;
        cmp_en_next    = issue;
        best_idx_next  = best_idx_reg;
        best_free_next = best_free_reg;
        found_next     = found_reg;
        if (cmd.capture) begin
            scan_idx_next = '0;
            cmp_en_next   = 1'b0;
            best_idx_next = '0;
            found_next    = 1'b0;
        end else begin
            if (issue) begin
                scan_idx_next = scan_idx_reg + 1'b1;
            end
            // strict less-than keeps the lowest index on ties
            if (cmp_en_reg && (rd_free >= size_reg) &&
                    (!found_reg || (rd_free < best_free_reg))) begin
                best_idx_next  = cmp_idx_reg;
                best_free_next = rd_free;
                found_next     = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_mem_reg <= mem[rd_addr];
        rd_vld_reg <= valid_reg[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (wr_en) begin
            valid_reg[wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg    <= bfba_pkg::BLOCK_COUNT_RST;
            scan_idx_reg <= '0;
            cmp_en_reg   <= 1'b0;
            found_reg    <= 1'b0;
        end else begin
            if (cfg_wr) begin
                count_reg <= cfg_data;
            end
            scan_idx_reg <= scan_idx_next;
            cmp_en_reg   <= cmp_en_next;
            found_reg    <= found_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            act_reg  <= in_action;
            idx_reg  <= in_index;
            size_reg <= in_size_ext[SIZE_BITS-1:0];
        end
        cmp_idx_reg   <= scan_idx_reg;
        best_idx_reg  <= best_idx_next;
        best_free_reg <= best_free_next;
    end

    // result payload register
    always_ff @(posedge aclk) begin
        if (cmd.finish) begin
            if (act_reg == bfba_pkg::ACT_LOAD) begin
                res_status    <= bfba_pkg::ST_LOADED;
                res_block     <= idx_reg;
                res_remaining <= idx_in_range ? size_ext[bfba_pkg::SZ_W-1:0] : '0;
            end else if (found_reg) begin
                res_status    <= bfba_pkg::ST_ALLOC;
                res_block     <= best_idx_reg[bfba_pkg::IDX_W-1:0];
                res_remaining <= diff_ext[bfba_pkg::SZ_W-1:0];
            end else begin
                res_status    <= bfba_pkg::ST_NONE;
                res_block     <= '0;
                res_remaining <= '0;
            end
        end
    end

endmodule
`default_nettype wire

FILE: rtl/core/bfba_controller.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bfba_controller
// Sequencer: accept a transaction, run the search for requests, then commit
// and hand the result to the output register.
// ----------------------------------------------------------------------------
module bfba_controller (
    input  wire                        aclk,
    input  wire                        aresetn,
    input  wire                        s_valid,
    output logic                       s_ready,
    input  wire                        s_action,
    output logic                       m_valid,
    input  wire                        m_ready,
    output bfba_pkg::ctrl_cmd_t        cmd,
    input  wire bfba_pkg::dp_status_t  status
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    logic [1:0] state_reg, state_next;
    logic       m_valid_reg, m_valid_next;
    logic       accept;

    assign s_ready = (state_reg == S_IDLE);
    assign accept  = s_valid && s_ready;
    assign m_valid = m_valid_reg;

    always_comb begin
        cmd.capture = accept;
        cmd.scan    = (state_reg == S_SCAN);
        cmd.finish  = (state_reg == S_DONE) && (!m_valid_reg || m_ready);
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    state_next = (s_action == bfba_pkg::ACT_REQUEST) ? S_SCAN : S_DONE;
                end
            end
            S_SCAN: begin
                if (status.scan_done) begin
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                if (cmd.finish) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.finish) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/core/bfba_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bfba_checker
// Port-level checks on the best-fit block allocator, bound to the top level.
// ----------------------------------------------------------------------------
module bfba_checker (
    input wire                            aclk,
    input wire                            aresetn,
    input wire                            s_tvalid,
    input wire                            s_tready,
    input wire                            m_tvalid,
    input wire                            m_tready,
    input wire [bfba_pkg::DATA_W-1:0]     m_tdata,
    input wire [bfba_pkg::STAT_W-1:0]     m_tuser
);

    // nothing is presented straight out of reset
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // a stalled result transaction holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // one item in work at a time: input closes after each accepted transaction
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted while busy");

    // a failed request reports block zero and size zero
    a_none_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == bfba_pkg::ST_NONE) |-> (m_tdata == '0))
        else $error("not-allocated result carries data");

    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser == bfba_pkg::ST_LOADED) || (m_tuser == bfba_pkg::ST_ALLOC) ||
                     (m_tuser == bfba_pkg::ST_NONE))
        else $error("undefined status code");

endmodule

bind best_fit_block_allocator bfba_checker u_bfba_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
`default_nettype wire

FILE: verif/best_fit_block_allocator_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// best_fit_block_allocator_tb
// Self-checking bench. Load and request transactions are streamed into the
// allocator with random gaps and random back-pressure on the result side. A
// scoreboard keeps its own copy of the free-size store and block_count,
// predicts every result and checks each one in order. block_count is changed
// between phases, its extremes among the settings.
// ----------------------------------------------------------------------------
module best_fit_block_allocator_tb;
    import bfba_pkg::*;

    localparam int NUM_BLOCKS   = 16;
    localparam int SIZE_BITS    = 16;
    localparam int HOLD_CYCLES  = 300;   // long receiver hold-off
    localparam int STALL_LIMIT  = 3000;  // cycles without any transaction
    localparam int DRAIN_CYCLES = 40;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [IDX_W-1:0]  block;
        logic [SZ_W-1:0]   remaining;
    } alloc_result_t;

    class alloc_scoreboard;
        logic [SIZE_BITS-1:0] free_size [NUM_BLOCKS];
        logic [CNT_W-1:0]     block_count;
        alloc_result_t        expected_q [$];
        int errors;
        int loads;
        int grants;
        int refusals;

        function new();
            foreach (free_size[i]) free_size[i] = '0;
            block_count = BLOCK_COUNT_RST;
            errors   = 0;
            loads    = 0;
            grants   = 0;
            refusals = 0;
        endfunction

        function void set_block_count(logic [CNT_W-1:0] value);
            block_count = value;
        endfunction

        // best fit: smallest free size that still holds the request, lowest index wins
        function void note_input(logic act, logic [IDX_W-1:0] idx, logic [SZ_W-1:0] size);
            alloc_result_t        r;
            logic [SIZE_BITS-1:0] want;
            int searched;
            int best;
            int j;
            want = size[SIZE_BITS-1:0];
            r    = '0;
            if (act == ACT_LOAD) begin
                r.status = ST_LOADED;
                r.block  = idx;
                if (int'(idx) < NUM_BLOCKS) begin
                    free_size[idx] = want;
                    r.remaining    = SZ_W'(want);
                end
                loads++;
            end else begin
                searched = (int'(block_count) > NUM_BLOCKS) ? NUM_BLOCKS : int'(block_count);
                best = -1;
                for (j = 0; j < searched; j++) begin
                    if (free_size[j] >= want && (best < 0 || free_size[j] < free_size[best]))
                        best = j;
                end
                if (best >= 0) begin
                    free_size[best] = free_size[best] - want;
                    r.status        = ST_ALLOC;
                    r.block         = IDX_W'(best);
                    r.remaining     = SZ_W'(free_size[best]);
                    grants++;
                end else begin
                    r.status = ST_NONE;
                    refusals++;
                end
            end
            expected_q.push_back(r);
        endfunction

        function void check_result(alloc_result_t got);
            alloc_result_t exp;
            if (expected_q.size() == 0) begin
                $error("result with nothing expected: status %0d block %0d remaining %0d",
                       got.status, got.block, got.remaining);
                errors++;
                return;
            end
            exp = expected_q.pop_front();
            if (got.status !== exp.status) begin
                $error("status mismatch: expected %0d, got %0d", exp.status, got.status);
                errors++;
            end
            if (got.block !== exp.block) begin
                $error("chosen_block mismatch: expected %0d, got %0d", exp.block, got.block);
                errors++;
            end
            if (got.remaining !== exp.remaining) begin
                $error("remaining_size mismatch: expected %0d, got %0d",
                       exp.remaining, got.remaining);
                errors++;
            end
        endfunction
    endclass

    logic              aclk      = 1'b0;
    logic              aresetn   = 1'b0;
    logic              s_tvalid  = 1'b0;
    logic              s_tready;
    logic [DATA_W-1:0] s_tdata   = '0;
    logic [0:0]        s_tuser   = '0;
    logic              m_tvalid;
    logic              m_tready  = 1'b0;
    logic [DATA_W-1:0] m_tdata;
    logic [STAT_W-1:0] m_tuser;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [CNT_W-1:0]  cfg_data  = '0;

    alloc_scoreboard sb;
    bit calm         = 1'b0;  // no gaps on either side
    bit hold_pending = 1'b0;  // receiver to hold off for HOLD_CYCLES
    int idle_cycles  = 0;
    int cfg_writes   = 0;

    best_fit_block_allocator #(
        .NUM_BLOCKS(NUM_BLOCKS),
        .SIZE_BITS (SIZE_BITS)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),    // [3:0] block_index, [19:4] size_value
        .s_tuser  (s_tuser),    // [0] action
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),    // [3:0] chosen_block, [19:4] remaining_size
        .m_tuser  (m_tuser),    // [1:0] status
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data)    // block_count
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= STALL_LIMIT) begin
                $display("simulation failed");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    // result side: random ready gaps, one long hold-off on request
    initial begin
        int gap;
        alloc_result_t got;
        wait (aresetn);
        @(negedge aclk);
        forever begin
            if (hold_pending) begin
                hold_pending = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
            end else begin
                gap = calm ? 0 : $urandom_range(0, 4);
                if (gap > 0) begin
                    m_tready <= 1'b0;
                    repeat (gap) @(negedge aclk);
                end
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            got.status    = m_tuser;
            got.block     = m_tdata[IDX_W-1:0];
            got.remaining = m_tdata[IDX_W +: SZ_W];
            sb.check_result(got);
            @(negedge aclk);
        end
    end

    // entered and left at a falling edge
    task automatic send_item(input logic act, input logic [IDX_W-1:0] idx,
                             input logic [SZ_W-1:0] size);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {{(DATA_W - IDX_W - SZ_W){1'b0}}, size, idx};
        do @(posedge aclk); while (!s_tready);
        sb.note_input(act, idx, size);
        @(negedge aclk);
    endtask

    task automatic write_block_count(input logic [CNT_W-1:0] value);
        s_tvalid <= 1'b0;
        while (sb.expected_q.size() != 0) @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        sb.set_block_count(value);
        cfg_writes++;
        @(negedge aclk);
        cfg_valid <= 1'b0;
        @(negedge aclk);
    endtask

    // request sizes aimed at the current free sizes: exact fits, near misses, small, wide
    function automatic logic [SZ_W-1:0] pick_request();
        int mode;
        logic [SZ_W-1:0] f;
        mode = $urandom_range(0, 99);
        f    = sb.free_size[$urandom_range(0, NUM_BLOCKS - 1)];
        if (mode < 30)      return f;
        else if (mode < 45) return f - 1'b1;
        else if (mode < 55) return f + 1'b1;
        else if (mode < 75) return SZ_W'($urandom_range(0, 15));
        else if (mode < 82) return '0;
        else                return SZ_W'($urandom_range(0, 16'hFFFF));
    endfunction

    function automatic logic [SZ_W-1:0] pick_load_size();
        int mode;
        mode = $urandom_range(0, 99);
        if (mode < 40)      return SZ_W'($urandom_range(0, 16'hFFFF));
        else if (mode < 65) return SZ_W'($urandom_range(0, 255));
        else if (mode < 75) return '1;
        else if (mode < 80) return '0;
        else                return sb.free_size[$urandom_range(0, NUM_BLOCKS - 1)];
    endfunction

    task automatic run_phase(input int n_items, input int load_pct, input bit with_hold);
        int i;
        // fresh contents so requests have something to work on
        for (i = 0; i < NUM_BLOCKS; i++)
            send_item(ACT_LOAD, IDX_W'(i), pick_load_size());
        for (i = 0; i < n_items; i++) begin
            calm = (i >= 20 && i < 60);
            if (with_hold && i == n_items / 2)
                hold_pending = 1'b1;
            if ($urandom_range(0, 99) < load_pct)
                send_item(ACT_LOAD, IDX_W'($urandom_range(0, 15)), pick_load_size());
            else
                send_item(ACT_REQUEST, IDX_W'($urandom_range(0, 15)), pick_request());
        end
        calm = 1'b0;
    endtask

    initial begin
        sb = new();
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // store is all zero after reset, block_count 16
        send_item(ACT_REQUEST, 4'd0,  16'd0);      // zero size fits block 0
        send_item(ACT_REQUEST, 4'd9,  16'd1);      // nothing fits
        send_item(ACT_LOAD,    4'd0,  16'hFFFF);
        send_item(ACT_LOAD,    4'd15, 16'hFFFF);
        send_item(ACT_REQUEST, 4'd15, 16'hFFFF);   // tie, lowest index
        send_item(ACT_REQUEST, 4'd0,  16'hFFFF);   // last block in the store
        send_item(ACT_LOAD,    4'd3,  16'd100);
        send_item(ACT_LOAD,    4'd9,  16'd100);
        send_item(ACT_LOAD,    4'd12, 16'd300);
        send_item(ACT_REQUEST, 4'd0,  16'd100);    // exact fit with a tie
        send_item(ACT_REQUEST, 4'd0,  16'd99);
        send_item(ACT_REQUEST, 4'd0,  16'd0);      // zero size: smallest block, unchanged
        send_item(ACT_REQUEST, 4'd0,  16'd301);
        send_item(ACT_LOAD,    4'd10, 16'hAAAA);
        send_item(ACT_LOAD,    4'd5,  16'h5555);
        send_item(ACT_REQUEST, 4'd0,  16'h5555);

        write_block_count(5'd0);                    // nothing searched
        send_item(ACT_REQUEST, 4'd0,  16'd0);
        send_item(ACT_LOAD,    4'd1,  16'd7);
        write_block_count(5'd1);
        send_item(ACT_REQUEST, 4'd0,  16'd0);
        send_item(ACT_REQUEST, 4'd0,  16'd1);
        write_block_count(5'd31);                   // saturates to the store size
        send_item(ACT_LOAD,    4'd15, 16'd5);
        send_item(ACT_REQUEST, 4'd0,  16'd5);
        send_item(ACT_REQUEST, 4'd0,  16'h8000);

        write_block_count(5'd16);
        run_phase(230, 35, 1'b1);
        write_block_count(CNT_W'($urandom_range(2, 15)));
        run_phase(180, 35, 1'b0);
        write_block_count(5'd31);
        run_phase(180, 30, 1'b0);
        write_block_count(5'd1);
        run_phase(100, 40, 1'b0);
        write_block_count(5'd0);
        run_phase(50, 40, 1'b0);
        write_block_count(5'd17);
        run_phase(180, 35, 1'b0);
        write_block_count(CNT_W'($urandom_range(0, 31)));
        run_phase(180, 35, 1'b0);
        write_block_count(5'd16);
        run_phase(160, 25, 1'b0);

        s_tvalid <= 1'b0;
        while (sb.expected_q.size() != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (sb.expected_q.size() != 0) begin
            $error("%0d results never arrived", sb.expected_q.size());
            sb.errors++;
        end

        $display("covered %0d loads, %0d grants and %0d refusals", sb.loads, sb.grants,
                 sb.refusals);
        $display("across %0d block_count settings, with back-pressure and one long hold-off",
                 cfg_writes);
        if (sb.errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
